// File: rtl/core/swm_pkg.sv
package swm_pkg;

  localparam int CFG_WIDTH    = 7;
  localparam int WINDOW_RESET = 3;

  typedef struct packed {
    logic clr;
    logic ins;
    logic del;
  } cell_op_t;

endpackage

// File: rtl/core/swm_if.sv
interface swm_sample_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median_value;

  modport source (output valid, output median_value, input ready);
  modport sink (input valid, input median_value, output ready);
endinterface

interface swm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swm_pkg::CFG_WIDTH-1:0]  window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

// File: rtl/core/swm_cell.sv
module swm_cell #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_pkg::cell_op_t              op,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] old_value,
  input  logic signed [SAMPLE_WIDTH-1:0] left_value,
  input  logic                           left_valid,
  input  logic                           left_le,
  input  logic signed [SAMPLE_WIDTH-1:0] right_value,
  input  logic                           right_valid,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic                           valid,
  output logic                           le
);
  import swm_pkg::*;

  logic ge;

  assign le = valid && (value <= sample);
  assign ge = valid && (value >= old_value);

  always_ff @(posedge clk) begin
    if (rst || op.clr) begin
      valid <= 1'b0;
    end else if (op.ins && !le) begin
      valid <= left_valid;
    end else if (op.del && ge) begin
      valid <= right_valid;
    end
  end

  // insert: take the new sample at the slot, shift the larger tail right; delete: take the right neighbor's value
  always_ff @(posedge clk) begin
    if (op.ins && !le) begin
      value <= left_le ? sample : left_value;
    end else if (op.del && ge) begin
      value <= right_value;
    end
  end

endmodule

// File: rtl/core/sliding_window_median.sv
// Running median filter over a sliding window of signed samples.
// samples (sink): one signed sample per transfer.
// medians (source): one median per sample once the window is full; with an
//   even window the lower of the two middle values is given.
// setup (sink): writes window_size (0 acts as 1, above MAX_WINDOW saturates)
//   and empties the window; always ready, write only while the block is idle.
// Throughput: while the window fills, one sample per cycle. Once full, each
//   sample passes an insert phase, which puts it into the sorted cell chain,
//   then a remove phase, which drops the oldest sample from the chain and
//   registers the median; no new sample is taken during the remove phase.
// The chain holds MAX_WINDOW cells; each compares against the new or the
//   oldest sample in parallel and shifts toward its neighbor.
// Reset: window size 3 (capped at MAX_WINDOW), window empty, no median pending.
// Stall: the median waits in the output register; the next sample is still
//   inserted, and its removal cycle holds until the median is taken.
module sliding_window_median #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  swm_sample_if.sink  samples,
  swm_median_if.source medians,
  swm_cfg_if.sink     setup
);
  import swm_pkg::*;

  localparam int CW      = $clog2(MAX_WINDOW + 1);
  localparam int IW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RESET_W = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

  typedef enum logic [1:0] {
    PH_INSERT = 2'b01,
    PH_REMOVE = 2'b10
  } phase_t;

  phase_t          phase;
  logic [CW-1:0]   weff;
  logic [CW-1:0]   fill;
  logic [IW-1:0]   med_idx;
  logic [IW-1:0]   old_idx;
  logic [IW-1:0]   wr_ptr;
  logic [IW-1:0]   rd_addr;
  logic [CW-1:0]   w_cfg;
  logic [CW-1:0]   fill_next;
  logic            in_xfer;
  logic            cfg_xfer;
  logic            out_free;
  logic            rem_fire;
  cell_op_t        op;

  logic signed [SAMPLE_WIDTH-1:0] hist [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] old_value;
  logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
  logic                           cell_valid [MAX_WINDOW];
  logic                           cell_le [MAX_WINDOW];
  logic                           med_valid;
  logic signed [SAMPLE_WIDTH-1:0] med_value;

  assign setup.ready   = 1'b1;
  assign cfg_xfer      = setup.valid && setup.ready;
  assign samples.ready = (phase == PH_INSERT);
  assign in_xfer       = samples.valid && samples.ready;
  assign out_free      = !med_valid || medians.ready;
  assign rem_fire      = (phase == PH_REMOVE) && out_free;
  assign fill_next     = fill + CW'(1);

  assign medians.valid        = med_valid;
  assign medians.median_value = med_value;

  assign op.clr = cfg_xfer;
  assign op.ins = in_xfer;
  assign op.del = rem_fire;

  always_comb begin
    if (setup.window_size == '0) begin
      w_cfg = CW'(1);
    end else if (int'(setup.window_size) > MAX_WINDOW) begin
      w_cfg = CW'(MAX_WINDOW);
    end else begin
      w_cfg = CW'(setup.window_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weff    <= CW'(RESET_W);
      med_idx <= IW'((RESET_W - 1) / 2);
      old_idx <= IW'(RESET_W - 1);
    end else if (cfg_xfer) begin
      weff    <= w_cfg;
      med_idx <= IW'((w_cfg - CW'(1)) >> 1);
      old_idx <= IW'(w_cfg - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_xfer) begin
      phase <= PH_INSERT;
      fill  <= '0;
    end else if (in_xfer) begin
      fill <= fill_next;
      if (fill_next == weff) begin
        phase <= PH_REMOVE;
      end
    end else if (rem_fire) begin
      fill  <= fill - CW'(1);
      phase <= PH_INSERT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      med_valid <= 1'b0;
    end else if (rem_fire) begin
      med_valid <= 1'b1;
    end else if (medians.ready) begin
      med_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rem_fire) begin
      med_value <= cell_value[med_idx];
    end
  end

  always_comb begin
    if (wr_ptr >= old_idx) begin
      rd_addr = wr_ptr - old_idx;
    end else begin
      rd_addr = IW'(MAX_WINDOW - int'(old_idx) + int'(wr_ptr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (in_xfer) begin
      if (wr_ptr == IW'(MAX_WINDOW - 1)) begin
        wr_ptr <= '0;
      end else begin
        wr_ptr <= wr_ptr + IW'(1);
      end
    end
  end

  // fetch the oldest sample of the window while the new one is inserted
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hist[wr_ptr] <= samples.sample;
      if (old_idx == '0) begin
        old_value <= samples.sample;
      end else begin
        old_value <= hist[rd_addr];
      end
    end
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] lval;
    logic                           lvld;
    logic                           lle;
    logic signed [SAMPLE_WIDTH-1:0] rval;
    logic                           rvld;

    if (g == 0) begin : g_head
      assign lval = samples.sample;
      assign lvld = 1'b1;
      assign lle  = 1'b1;
    end else begin : g_mid
      assign lval = cell_value[g-1];
      assign lvld = cell_valid[g-1];
      assign lle  = cell_le[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rval = cell_value[g+1];
      assign rvld = cell_valid[g+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .sample     (samples.sample),
      .old_value  (old_value),
      .left_value (lval),
      .left_valid (lvld),
      .left_le    (lle),
      .right_value(rval),
      .right_valid(rvld),
      .value      (cell_value[g]),
      .valid      (cell_valid[g]),
      .le         (cell_le[g])
    );
  end

endmodule
